// ===== src/tpo_pkg.sv =====
// ----------------------------------------------------------------------------
// tpo_pkg
// Shared constants, types and constant functions for the Tukey pulse
// oscillator: sizes, register indexes, the exp2 step table and the ramp table.
// ----------------------------------------------------------------------------
package tpo_pkg;

    // Sizes of the design.
    localparam int CHANNELS          = 16;
    localparam int PHASE_BITS        = 32;
    localparam int COSINE_TABLE_BITS = 10;

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Ramp table covers u = 0 .. half a table turn.
    localparam int RAMP_DEPTH  = (1 << (COSINE_TABLE_BITS - 1)) + 1;
    localparam int RAMP_ADDR_W = $clog2(RAMP_DEPTH);

    // Sequencer counter covers the exp2 steps and the quotient bits.
    localparam int EXP_STEPS = 11;
    localparam int CNT_W = $clog2((COSINE_TABLE_BITS > EXP_STEPS) ?
                                  COSINE_TABLE_BITS : EXP_STEPS);

    // Phase step shift is 62 - octave - PHASE_BITS, octave = q[15:11] - 10.
    localparam int SHIFT_BASE = 72 - PHASE_BITS;

    // Register indexes of the configuration port.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH_OFFSET = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_KNOB   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAPER_KNOB   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LFO_MODE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BIPOLAR_MODE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_C4_INCREMENT = 3'd5;

    // Reset values of the registers.
    localparam logic [15:0] WIDTH_KNOB_RESET   = 16'd32768;
    localparam logic [15:0] TAPER_KNOB_RESET   = 16'd32768;
    localparam logic [31:0] C4_INCREMENT_RESET = 32'd23409861;

    // Fixed point constants.
    localparam logic [63:0] ONE_Q30  = 64'd1073741824;
    localparam logic [63:0] HALF_Q30 = 64'd536870912;
    localparam logic [63:0] PI_Q30   = 64'd3373259426;

    // Voltages in Q5.11.
    localparam logic signed [17:0] PITCH_MIN   = -18'sd20480;
    localparam logic signed [17:0] PITCH_MAX   = 18'sd20480;
    localparam logic signed [17:0] LFO_SHIFT   = 18'sd10240;
    localparam logic [15:0]        LEVEL_TOP   = 16'd20480;
    localparam logic [15:0]        BIPOLAR_SHIFT = 16'd10240;

    // Knob range in Q0.16, and 2^24 / 5 rounded up for the CV / 10 scaling.
    localparam logic signed [18:0] KNOB_MAX   = 19'sd65536;
    localparam logic [21:0]        DIV5_RECIP = 22'd3355444;

    // 2^(2^b / 2048) in Q30.
    localparam logic [30:0] EXP2_STEP [EXP_STEPS] = '{
        31'd1074105294, 31'd1074468888, 31'd1075196443, 31'd1076653033,
        31'd1079572136, 31'd1085434106, 31'd1097253708, 31'd1121280436,
        31'd1170923762, 31'd1276901417, 31'd1518500250
    };

    // Divisors (2k)(2k+1) of the sine series terms.
    localparam logic [63:0] TAYLOR_DIV [6] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156
    };

    typedef logic [15:0] ramp_rom_t [RAMP_DEPTH];

    // Request from the sequencer to the phase store.
    typedef struct packed {
        logic                  rd_en;
        logic                  wr_en;
        logic [IDX_W-1:0]      addr;
        logic [PHASE_BITS-1:0] wdata;
    } phase_req_t;

    // Level of a ramp point: 20480 * sin^2(pi * u / 2^COSINE_TABLE_BITS).
    function automatic logic [15:0] ramp_level(input int unsigned u);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] s;
        longint      sum;
        x    = (PI_Q30 * 64'(u)) >> COSINE_TABLE_BITS;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (int k = 1; k <= 6; k++) begin
            term = (term * x2) >> 30;
            term = term / TAYLOR_DIV[k-1];
            if ((k % 2) == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        s = 64'(sum);
        if (s > ONE_Q30) begin
            s = ONE_Q30;
        end
        s = (s * s) >> 30;
        return 16'((64'd20480 * s + HALF_Q30) >> 30);
    endfunction

    // Whole ramp table, built at elaboration.
    function automatic ramp_rom_t ramp_table();
        ramp_rom_t t;
        for (int i = 0; i < RAMP_DEPTH; i++) begin
            t[i] = ramp_level(i);
        end
        return t;
    endfunction

    // Channel number to phase store entry.
    function automatic logic [IDX_W-1:0] chan_index(input logic [3:0] ch);
        logic [IDX_W-1:0] r;
        r = '0;
        for (int v = 0; v < 16; v++) begin
            if (ch == 4'(v)) begin
                r = IDX_W'(v % CHANNELS);
            end
        end
        return r;
    endfunction

    // Phase aligned to a Q0.32 cycle fraction.
    function automatic logic [31:0] phase_to_q32(input logic [PHASE_BITS-1:0] p);
        logic [31:0] r;
        r = '0;
        for (int i = 0; i < 32; i++) begin
            if ((i + PHASE_BITS - 32 >= 0) && (i + PHASE_BITS - 32 < PHASE_BITS)) begin
                r[i] = p[i + PHASE_BITS - 32];
            end
        end
        return r;
    endfunction

endpackage

// ===== src/tpo_phase_store.sv =====
// ----------------------------------------------------------------------------
// tpo_phase_store
// Per-channel phase memory with a registered read port and one write port.
// Valid bits cleared by reset make unwritten entries read as zero.
// ----------------------------------------------------------------------------
module tpo_phase_store (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  tpo_pkg::phase_req_t           req,
    output logic [tpo_pkg::PHASE_BITS-1:0] rd_data
);

    logic [tpo_pkg::PHASE_BITS-1:0] mem [tpo_pkg::CHANNELS];
    logic [tpo_pkg::CHANNELS-1:0]   valid_reg;
    logic [tpo_pkg::PHASE_BITS-1:0] rdata_reg;
    logic                           rvalid_reg;

    // Memory array write and registered read.
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.addr] <= req.wdata;
        end
        if (req.rd_en) begin
            rdata_reg <= mem[req.addr];
        end
    end

    // Entry valid bits, cleared at reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end else begin
            if (req.wr_en) begin
                valid_reg[req.addr] <= 1'b1;
            end
            if (req.rd_en) begin
                rvalid_reg <= valid_reg[req.addr];
            end
        end
    end

    assign rd_data = rvalid_reg ? rdata_reg : '0;

endmodule

// ===== src/tpo_ramp_rom.sv =====
// ----------------------------------------------------------------------------
// tpo_ramp_rom
// Raised-cosine ramp levels for one half turn, with a registered read.
// ----------------------------------------------------------------------------
module tpo_ramp_rom (
    input  logic                            aclk,
    input  logic                            rd_en,
    input  logic [tpo_pkg::RAMP_ADDR_W-1:0] addr,
    output logic [15:0]                     data
);

    localparam tpo_pkg::ramp_rom_t ROM = tpo_pkg::ramp_table();

    logic [15:0] data_reg;

    // Registered table read.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            data_reg <= ROM[addr];
        end
    end

    assign data = data_reg;

endmodule

// ===== src/tukey_pulse_oscillator_top.sv =====
// ----------------------------------------------------------------------------
// tukey_pulse_oscillator_top
// Polyphonic phase accumulator oscillator with a Tukey window output shape.
// ----------------------------------------------------------------------------
//  Channel   | Direction | Handshake           | Payload
//  input     | in        | s_valid / s_ready   | s_channel, s_pitch_cv, s_width_cv, s_taper_cv
//  result    | out       | m_valid / m_ready   | m_out_channel, m_level
//  config    | in        | cfg_wr_en           | cfg_index, cfg_wdata
//
// One transaction is worked on at a time. The 11 exp2 multiply steps set
// the spacing of accepted transactions on the flat part of the window; on
// a ramp the one-bit-per-cycle ramp divider adds to it.
// The result register holds a finished transaction while the next is taken;
// a stalled output only holds the sequencer in its last step.
// Reset is synchronous; the phase store reads as zero until each entry is
// written, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module tukey_pulse_oscillator_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [tpo_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [3:0]                    s_channel,
    input  logic signed [15:0]            s_pitch_cv,
    input  logic signed [15:0]            s_width_cv,
    input  logic signed [15:0]            s_taper_cv,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [3:0]                    m_out_channel,
    output logic signed [15:0]            m_level
);

    localparam int PB  = tpo_pkg::PHASE_BITS;
    localparam int CTB = tpo_pkg::COSINE_TABLE_BITS;
    localparam int CW  = tpo_pkg::CNT_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EXP  = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_ADD  = 3'd3;
    localparam logic [2:0] ST_CMP  = 3'd4;
    localparam logic [2:0] ST_DIV  = 3'd5;
    localparam logic [2:0] ST_ROM  = 3'd6;
    localparam logic [2:0] ST_FIN  = 3'd7;

    // Configuration registers.
    logic signed [15:0] pitch_offset_reg;
    logic [15:0]        width_knob_reg;
    logic [15:0]        taper_knob_reg;
    logic               lfo_mode_reg;
    logic               bipolar_mode_reg;
    logic [31:0]        c4_increment_reg;

    // Sequencer and datapath registers.
    logic [2:0]         state_reg;
    logic [2:0]         state_next;
    logic [CW-1:0]      cnt_reg;
    logic [3:0]         chan_reg;
    logic [10:0]        frac_reg;
    logic [4:0]         oct_reg;
    logic [31:0]        m_reg;
    logic signed [15:0] width_cv_reg;
    logic signed [15:0] taper_cv_reg;
    logic [16:0]        w_quot_reg;
    logic [16:0]        a_quot_reg;
    logic [16:0]        w_reg;
    logic [16:0]        a_reg;
    logic [32:0]        t_reg;
    logic [63:0]        prod_reg;
    logic [31:0]        x_reg;
    logic [32:0]        rem_reg;
    logic [CTB-1:0]     u_reg;
    logic               is_ramp_reg;
    logic [15:0]        flat_reg;
    logic               m_valid_reg;
    logic [3:0]         m_chan_reg;
    logic signed [15:0] m_level_reg;

    tpo_pkg::phase_req_t   phase_req;
    logic [PB-1:0]         phase_rd;
    logic [15:0]           rom_data;

    logic                  accept;
    logic                  out_free;
    logic signed [17:0]    pitch_sum;
    logic signed [17:0]    pitch_clamp;
    logic [15:0]           pitch_q;
    logic [31:0]           m_step;
    logic [6:0]            shift_amt;
    logic [63:0]           step_full;
    logic [PB-1:0]         phase_new;
    logic [32:0]           wq;
    logic [33:0]           x2;
    logic [33:0]           rem2;
    logic                  rem_ge;
    logic [15:0]           level_raw;

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;

    // Magnitude of CV * 16, scaled by 1/5 through a reciprocal multiply.
    function automatic logic [16:0] cv_div(input logic signed [15:0] cv);
        logic [15:0] mag;
        logic [19:0] mag16;
        mag   = cv[15] ? 16'(-cv) : 16'(cv);
        mag16 = {mag, 4'b0};
        return 17'((42'(mag16) * 42'(tpo_pkg::DIV5_RECIP)) >> 24);
    endfunction

    // Knob plus signed quotient, clamped to 0 .. 1.0 in Q0.16.
    function automatic logic [16:0] knob_clamp(input logic [15:0] knob,
                                               input logic [16:0] quot,
                                               input logic neg);
        logic signed [18:0] v;
        v = neg ? (19'($signed({1'b0, knob})) - 19'($signed({1'b0, quot})))
                : (19'($signed({1'b0, knob})) + 19'($signed({1'b0, quot})));
        if (v < 0) begin
            return '0;
        end
        if (v > tpo_pkg::KNOB_MAX) begin
            return 17'(tpo_pkg::KNOB_MAX);
        end
        return 17'(v);
    endfunction

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pitch_offset_reg <= '0;
            width_knob_reg   <= tpo_pkg::WIDTH_KNOB_RESET;
            taper_knob_reg   <= tpo_pkg::TAPER_KNOB_RESET;
            lfo_mode_reg     <= 1'b0;
            bipolar_mode_reg <= 1'b0;
            c4_increment_reg <= tpo_pkg::C4_INCREMENT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                tpo_pkg::CFG_PITCH_OFFSET: pitch_offset_reg <= cfg_wdata[15:0];
                tpo_pkg::CFG_WIDTH_KNOB:   width_knob_reg   <= cfg_wdata[15:0];
                tpo_pkg::CFG_TAPER_KNOB:   taper_knob_reg   <= cfg_wdata[15:0];
                tpo_pkg::CFG_LFO_MODE:     lfo_mode_reg     <= cfg_wdata[0];
                tpo_pkg::CFG_BIPOLAR_MODE: bipolar_mode_reg <= cfg_wdata[0];
                tpo_pkg::CFG_C4_INCREMENT: c4_increment_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Pitch sum and clamp on the incoming transaction.
    always_comb begin
        pitch_sum = 18'(pitch_offset_reg) + 18'(s_pitch_cv)
                  - (lfo_mode_reg ? tpo_pkg::LFO_SHIFT : 18'sd0);
        if (pitch_sum < tpo_pkg::PITCH_MIN) begin
            pitch_clamp = tpo_pkg::PITCH_MIN;
        end else if (pitch_sum > tpo_pkg::PITCH_MAX) begin
            pitch_clamp = tpo_pkg::PITCH_MAX;
        end else begin
            pitch_clamp = pitch_sum;
        end
        pitch_q = 16'(pitch_clamp - tpo_pkg::PITCH_MIN);
    end

    // Datapath arithmetic of the individual steps.
    assign m_step    = 32'((64'(m_reg) * 64'(tpo_pkg::EXP2_STEP[cnt_reg])
                            + tpo_pkg::HALF_Q30) >> 30);
    assign shift_amt = 7'(tpo_pkg::SHIFT_BASE) - 7'(oct_reg);
    assign step_full = prod_reg >> shift_amt;
    assign phase_new = phase_rd + step_full[PB-1:0];
    assign wq        = {w_reg, 16'b0};
    assign x2        = {1'b0, x_reg, 1'b0};
    assign rem2      = {rem_reg, 1'b0};
    assign rem_ge    = (rem2 >= {1'b0, t_reg});

    // Phase store requests: read on accept, write back after the add.
    always_comb begin
        phase_req       = '0;
        phase_req.wdata = phase_new;
        if (state_reg == ST_IDLE) begin
            phase_req.rd_en = accept;
            phase_req.addr  = tpo_pkg::chan_index(s_channel);
        end else begin
            phase_req.wr_en = (state_reg == ST_ADD);
            phase_req.addr  = tpo_pkg::chan_index(chan_reg);
        end
    end

    tpo_phase_store u_phase_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (phase_req),
        .rd_data (phase_rd)
    );

    tpo_ramp_rom u_ramp_rom (
        .aclk  (aclk),
        .rd_en (state_reg == ST_ROM),
        .addr  (tpo_pkg::RAMP_ADDR_W'(u_reg)),
        .data  (rom_data)
    );

    // Next state of the sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept) state_next = ST_EXP;
            ST_EXP:  if (cnt_reg == CW'(tpo_pkg::EXP_STEPS - 1)) state_next = ST_MUL;
            ST_MUL:  state_next = ST_ADD;
            ST_ADD:  state_next = ST_CMP;
            ST_CMP: begin
                if ((w_reg != '0) && ((x2 < {1'b0, t_reg}) ||
                    ((x2 + {1'b0, t_reg} > {wq, 1'b0}) && ({1'b0, x_reg} < wq)))) begin
                    state_next = ST_DIV;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_DIV:  if (cnt_reg == CW'(CTB - 1)) state_next = ST_ROM;
            ST_ROM:  state_next = ST_FIN;
            ST_FIN:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer state and step counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (state_next != state_reg) begin
                cnt_reg <= '0;
            end else begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                chan_reg     <= s_channel;
                frac_reg     <= pitch_q[10:0];
                oct_reg      <= pitch_q[15:11];
                m_reg        <= tpo_pkg::ONE_Q30[31:0];
                width_cv_reg <= s_width_cv;
                taper_cv_reg <= s_taper_cv;
            end
            ST_EXP: begin
                // One exp2 factor per cycle, in ascending bit order.
                if (frac_reg[cnt_reg]) begin
                    m_reg <= m_step;
                end
                // Width and taper are settled over the first cycles.
                if (cnt_reg == CW'(0)) begin
                    w_quot_reg <= cv_div(width_cv_reg);
                    a_quot_reg <= cv_div(taper_cv_reg);
                end
                if (cnt_reg == CW'(1)) begin
                    w_reg <= knob_clamp(width_knob_reg, w_quot_reg, width_cv_reg[15]);
                    a_reg <= knob_clamp(taper_knob_reg, a_quot_reg, taper_cv_reg[15]);
                end
                if (cnt_reg == CW'(2)) begin
                    t_reg <= 33'(34'(w_reg) * 34'(a_reg));
                end
            end
            ST_MUL: begin
                prod_reg <= 64'(c4_increment_reg) * 64'(m_reg);
            end
            ST_ADD: begin
                x_reg <= tpo_pkg::phase_to_q32(phase_new);
            end
            ST_CMP: begin
                // Region of the window: rise, flat top, fall or zero.
                u_reg <= '0;
                if (w_reg == '0) begin
                    is_ramp_reg <= 1'b0;
                    flat_reg    <= '0;
                end else if (x2 < {1'b0, t_reg}) begin
                    is_ramp_reg <= 1'b1;
                    rem_reg     <= {1'b0, x_reg};
                end else if (x2 + {1'b0, t_reg} <= {wq, 1'b0}) begin
                    is_ramp_reg <= 1'b0;
                    flat_reg    <= tpo_pkg::LEVEL_TOP;
                end else if ({1'b0, x_reg} < wq) begin
                    is_ramp_reg <= 1'b1;
                    rem_reg     <= wq - {1'b0, x_reg};
                end else begin
                    is_ramp_reg <= 1'b0;
                    flat_reg    <= '0;
                end
            end
            ST_DIV: begin
                // Restoring division, one quotient bit per cycle.
                if (rem_ge) begin
                    rem_reg <= 33'(rem2 - {1'b0, t_reg});
                end else begin
                    rem_reg <= rem2[32:0];
                end
                u_reg <= {u_reg[CTB-2:0], rem_ge};
            end
            default: ;
        endcase
    end

    assign level_raw = is_ramp_reg ? rom_data : flat_reg;

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_FIN && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_FIN && out_free) begin
            m_chan_reg  <= chan_reg;
            m_level_reg <= $signed(level_raw
                           - (bipolar_mode_reg ? tpo_pkg::BIPOLAR_SHIFT : 16'd0));
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_channel = m_chan_reg;
    assign m_level       = m_level_reg;

endmodule

// ===== src/tpo_checker.sv =====
// ----------------------------------------------------------------------------
// tpo_checker
// Port-level checks of the oscillator, attached to the top level by bind.
// ----------------------------------------------------------------------------
module tpo_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          cfg_wr_en,
    input logic [tpo_pkg::CFG_IDX_W-1:0] cfg_index,
    input logic [31:0]                   cfg_wdata,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic [3:0]                    s_channel,
    input logic signed [15:0]            s_pitch_cv,
    input logic signed [15:0]            s_width_cv,
    input logic signed [15:0]            s_taper_cv,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [3:0]                    m_out_channel,
    input logic signed [15:0]            m_level
);

    // No result is shown right after reset.
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A transaction is worked on alone: input closes after an accept.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted twice in a row");

    // The level stays within -5 V .. +10 V.
    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_level >= -16'sd10240) && (m_level <= 16'sd20480))
        else $error("level out of range");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid && $stable(m_level)
                                  && $stable(m_out_channel))
        else $error("stalled result changed");

endmodule

bind tukey_pulse_oscillator_top tpo_checker u_tpo_checker (.*);
